// File: hdl/sawm_pkg.sv
// ----------------------------------------------------------------------------
// sawm_pkg: shared types and constants of the stack allocator
// Opcodes, status codes, register map and widths used by the top, controller, registers and bench.
// ----------------------------------------------------------------------------
package sawm_pkg;

	// Size record stack
	localparam int RECORD_DEPTH = 256;
	localparam int DEPTH_BITS   = $clog2(RECORD_DEPTH);
	localparam int CNT_BITS     = $clog2(RECORD_DEPTH + 1);

	// Offsets and field widths
	localparam int OFFSET_BITS = 21;
	localparam int SIZE_BITS   = 21;
	localparam int ADDR_BITS   = 32;
	localparam int COUNT_BITS  = 32;
	localparam logic [OFFSET_BITS-1:0] OFFSET_MASK = '1;

	// Opcodes
	localparam logic [2:0] OP_ALLOC = 3'd0;
	localparam logic [2:0] OP_FREE  = 3'd1;
	localparam logic [2:0] OP_CLEAR = 3'd2;
	localparam logic [2:0] OP_MARK  = 3'd3;
	localparam logic [2:0] OP_FTM   = 3'd4;

	// Status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_IGNORED    = 3'd1;
	localparam logic [2:0] ST_NO_SPACE   = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_NOT_LAST   = 3'd4;
	localparam logic [2:0] ST_BAD_MARKER = 3'd5;

	// Register map: word index taken from paddr[2]
	localparam int APB_AW = 3;
	localparam logic REG_BUFFER_BASE = 1'b0;
	localparam logic REG_BUFFER_SIZE = 1'b1;
	localparam logic [ADDR_BITS-1:0] BASE_RESET = 32'd4096;
	localparam logic [SIZE_BITS-1:0] SIZE_RESET = 21'd65536;

	// Configuration seen by the controller
	typedef struct packed {
		logic [ADDR_BITS-1:0] base;
		logic [SIZE_BITS-1:0] size;
	} cfg_t;

endpackage

// File: hdl/stack_allocator_with_markers_top.sv
// ----------------------------------------------------------------------------
// stack_allocator_with_markers_top: bump-pointer stack allocator with markers
// Allocate, free-last, clear, obtain-marker and free-to-marker over one buffer.
// ----------------------------------------------------------------------------
//  channel  | handshake                          | payload
//  ---------+------------------------------------+--------------------------------
//  request  | start, busy (taken: start & !busy) | opcode, num_bytes, address
//  result   | done (one-cycle strobe)            | status, result_address,
//           |                                    | alloc_count, free_count,
//           |                                    | live_blocks
//  config   | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
//  Allocate, clear, obtain-marker, unknown opcodes and requests refused
//  up front finish in the accepting cycle; free reads one record in S_FREE first.
//  Free-to-marker then examines the records in S_WALK, one per cycle,
//  through the record RAM read port.
//  The result strobe rises the cycle after the last cycle of work; the next
//  transaction may be taken in that same cycle. The receiver cannot stall.
//  Reset clears the top, the depth and both counters; the record RAM needs
//  no clearing pass.
// ----------------------------------------------------------------------------
module stack_allocator_with_markers_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        opcode,
	input  logic [sawm_pkg::SIZE_BITS-1:0]    num_bytes,
	input  logic [sawm_pkg::ADDR_BITS-1:0]    address,
	output logic                              done,
	output logic [2:0]                        status,
	output logic [sawm_pkg::ADDR_BITS-1:0]    result_address,
	output logic [sawm_pkg::COUNT_BITS-1:0]   alloc_count,
	output logic [sawm_pkg::COUNT_BITS-1:0]   free_count,
	output logic [sawm_pkg::CNT_BITS-1:0]     live_blocks,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sawm_pkg::APB_AW-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import sawm_pkg::*;

	cfg_t                  cfg;
	logic                  mem_we;
	logic [DEPTH_BITS-1:0] mem_waddr;
	logic [SIZE_BITS-1:0]  mem_wdata;
	logic                  mem_re;
	logic [DEPTH_BITS-1:0] mem_raddr;
	logic [SIZE_BITS-1:0]  mem_rdata;

	// Configuration registers
	sawm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Size record stack storage
	sawm_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (RECORD_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Allocator sequencer
	sawm_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.num_bytes      (num_bytes),
		.address        (address),
		.done           (done),
		.status         (status),
		.result_address (result_address),
		.alloc_count    (alloc_count),
		.free_count     (free_count),
		.live_blocks    (live_blocks),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_re         (mem_re),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

endmodule

// File: hdl/sawm_ram.sv
// ----------------------------------------------------------------------------
// sawm_ram: simple dual-port synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sawm_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 256,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/sawm_regs.sv
// ----------------------------------------------------------------------------
// sawm_regs: APB configuration registers
// Holds the buffer base address and the buffer size.
// ----------------------------------------------------------------------------
module sawm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sawm_pkg::APB_AW-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output sawm_pkg::cfg_t                cfg
);
	import sawm_pkg::*;

	logic [ADDR_BITS-1:0] base_q;
	logic [SIZE_BITS-1:0] size_q;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Capture writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			size_q <= SIZE_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_BUFFER_BASE: base_q <= pwdata;
				REG_BUFFER_SIZE: size_q <= pwdata[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[2])
			REG_BUFFER_BASE: prdata = base_q;
			REG_BUFFER_SIZE: prdata = 32'(size_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.base = base_q;
	assign cfg.size = size_q;

endmodule

// File: hdl/sawm_ctrl.sv
// ----------------------------------------------------------------------------
// sawm_ctrl: allocator sequencer
// Keeps top offset, record depth and counters; drives the size record RAM.
// ----------------------------------------------------------------------------
module sawm_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sawm_pkg::cfg_t                    cfg,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        opcode,
	input  logic [sawm_pkg::SIZE_BITS-1:0]    num_bytes,
	input  logic [sawm_pkg::ADDR_BITS-1:0]    address,
	output logic                              done,
	output logic [2:0]                        status,
	output logic [sawm_pkg::ADDR_BITS-1:0]    result_address,
	output logic [sawm_pkg::COUNT_BITS-1:0]   alloc_count,
	output logic [sawm_pkg::COUNT_BITS-1:0]   free_count,
	output logic [sawm_pkg::CNT_BITS-1:0]     live_blocks,
	output logic                              mem_we,
	output logic [sawm_pkg::DEPTH_BITS-1:0]   mem_waddr,
	output logic [sawm_pkg::SIZE_BITS-1:0]    mem_wdata,
	output logic                              mem_re,
	output logic [sawm_pkg::DEPTH_BITS-1:0]   mem_raddr,
	input  logic [sawm_pkg::SIZE_BITS-1:0]    mem_rdata
);
	import sawm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FREE,
		S_WALK
	} state_t;

	state_t                 state_q, state_d;
	logic [OFFSET_BITS-1:0] top_q, top_d;
	logic [CNT_BITS-1:0]    depth_q, depth_d;
	logic [COUNT_BITS-1:0]  allocs_q, allocs_d;
	logic [COUNT_BITS-1:0]  frees_q, frees_d;
	logic [OFFSET_BITS-1:0] cur_q, cur_d;
	logic [CNT_BITS-1:0]    pos_q, pos_d;
	logic [ADDR_BITS-1:0]   opnd_q, opnd_d;
	logic                   done_q;
	logic [2:0]             status_q, st_d;
	logic [ADDR_BITS-1:0]   res_q, res_d;

	logic                   accept;
	logic                   fin;
	logic                   use_alloc;
	logic [ADDR_BITS-1:0]   alloc_res;
	logic [ADDR_BITS-1:0]   cap32;
	logic [ADDR_BITS-1:0]   top32;
	logic [ADDR_BITS-1:0]   top_addr;
	logic [ADDR_BITS-1:0]   off32;
	logic [OFFSET_BITS-1:0] last_sz;
	logic [OFFSET_BITS-1:0] ncur;
	logic [CNT_BITS-1:0]    npos;

	assign accept   = start && (state_q == S_IDLE);
	assign busy     = (state_q != S_IDLE);
	assign top32    = ADDR_BITS'(top_q);
	assign top_addr = cfg.base + top32;
	assign off32    = address - cfg.base;
	assign cap32    = (ADDR_BITS'(cfg.size) > ADDR_BITS'(OFFSET_MASK)) ?
		ADDR_BITS'(OFFSET_MASK) : ADDR_BITS'(cfg.size);
	assign last_sz  = OFFSET_BITS'(mem_rdata);
	assign ncur     = cur_q - last_sz;
	assign npos     = pos_q - 1'b1;

	// Decide the next state of the allocator
	always_comb begin
		state_d   = state_q;
		top_d     = top_q;
		depth_d   = depth_q;
		allocs_d  = allocs_q;
		frees_d   = frees_q;
		cur_d     = cur_q;
		pos_d     = pos_q;
		opnd_d    = opnd_q;
		fin       = 1'b0;
		st_d      = ST_OK;
		use_alloc = 1'b0;
		alloc_res = '0;
		mem_we    = 1'b0;
		mem_waddr = depth_q[DEPTH_BITS-1:0];
		mem_wdata = num_bytes;
		mem_re    = 1'b0;
		mem_raddr = DEPTH_BITS'(depth_q - 1'b1);

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_ALLOC: begin
							fin       = 1'b1;
							use_alloc = 1'b1;
							if (top32 > cap32 || (cap32 - top32) < ADDR_BITS'(num_bytes)) begin
								st_d = ST_NO_SPACE;
							end else if (depth_q >= CNT_BITS'(RECORD_DEPTH)) begin
								st_d = ST_FULL;
							end else begin
								alloc_res = top_addr;
								top_d     = top_q + OFFSET_BITS'(num_bytes);
								depth_d   = depth_q + 1'b1;
								allocs_d  = allocs_q + 1'b1;
								mem_we    = 1'b1;
							end
						end
						OP_FREE: begin
							if (address == '0) begin
								fin  = 1'b1;
								st_d = ST_IGNORED;
							end else if (depth_q == '0) begin
								fin  = 1'b1;
								st_d = ST_NOT_LAST;
							end else begin
								mem_re  = 1'b1;
								opnd_d  = address;
								state_d = S_FREE;
							end
						end
						OP_CLEAR: begin
							fin      = 1'b1;
							top_d    = '0;
							depth_d  = '0;
							allocs_d = '0;
							frees_d  = '0;
						end
						OP_MARK: begin
							fin = 1'b1;
						end
						OP_FTM: begin
							if (address == '0 || address == top_addr) begin
								fin  = 1'b1;
								st_d = ST_IGNORED;
							end else if (off32 >= top32 || depth_q == '0) begin
								fin  = 1'b1;
								st_d = ST_BAD_MARKER;
							end else begin
								mem_re  = 1'b1;
								cur_d   = top_q;
								pos_d   = depth_q;
								opnd_d  = off32;
								state_d = S_WALK;
							end
						end
						default: begin
							fin  = 1'b1;
							st_d = ST_IGNORED;
						end
					endcase
				end
			end
			S_FREE: begin
				// Pop only if the address matches the last block
				fin     = 1'b1;
				state_d = S_IDLE;
				if (last_sz > top_q ||
					opnd_q != cfg.base + ADDR_BITS'(top_q - last_sz)) begin
					st_d = ST_NOT_LAST;
				end else begin
					top_d   = top_q - last_sz;
					depth_d = depth_q - 1'b1;
					frees_d = frees_q + 1'b1;
				end
			end
			S_WALK: begin
				// Prefetch the record below the one being examined
				mem_re    = 1'b1;
				mem_raddr = DEPTH_BITS'(pos_q - 2'd2);
				if (last_sz > cur_q) begin
					fin     = 1'b1;
					st_d    = ST_BAD_MARKER;
					state_d = S_IDLE;
				end else if (ncur == opnd_q[OFFSET_BITS-1:0]) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					top_d   = ncur;
					depth_d = npos;
					frees_d = frees_q + COUNT_BITS'(depth_q - npos);
				end else if (ncur < opnd_q[OFFSET_BITS-1:0] || npos == '0) begin
					fin     = 1'b1;
					st_d    = ST_BAD_MARKER;
					state_d = S_IDLE;
				end else begin
					cur_d = ncur;
					pos_d = npos;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res_d = use_alloc ? alloc_res : (cfg.base + ADDR_BITS'(top_d));
	end

	// Hold state and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			top_q    <= '0;
			depth_q  <= '0;
			allocs_q <= '0;
			frees_q  <= '0;
			done_q   <= 1'b0;
			cur_q    <= '0;
			pos_q    <= '0;
			opnd_q   <= '0;
			status_q <= ST_OK;
			res_q    <= '0;
		end else begin
			state_q  <= state_d;
			top_q    <= top_d;
			depth_q  <= depth_d;
			allocs_q <= allocs_d;
			frees_q  <= frees_d;
			done_q   <= fin;
			cur_q    <= cur_d;
			pos_q    <= pos_d;
			opnd_q   <= opnd_d;
			if (fin) begin
				status_q <= st_d;
				res_q    <= res_d;
			end
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign result_address = res_q;
	assign alloc_count    = allocs_q;
	assign free_count     = frees_q;
	assign live_blocks    = depth_q;

	// Record depth never passes the stack size
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CNT_BITS'(RECORD_DEPTH))
		else $error("record depth beyond stack size");

	// The walk only runs with records left to pop
	a_walk_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (pos_q != '0 && pos_q <= depth_q))
		else $error("walk position out of range");

	// A result only follows an accepted transaction or ongoing work
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(accept || state_q != S_IDLE))
		else $error("result without a transaction");

	// Clear empties the stack at once
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_CLEAR) |=> (done_q && depth_q == '0 && top_q == '0))
		else $error("clear did not empty the stack");

endmodule

// File: bench/stack_allocator_with_markers_top_tb.sv
// ----------------------------------------------------------------------------
// stack_allocator_with_markers_top_tb: self-checking bench of the stack allocator
// Drives allocate, free, clear, marker and free-to-marker requests through the
// start/busy port and reprograms the buffer over APB between phases. A local
// copy of the allocator state predicts every reply, and each done strobe is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module stack_allocator_with_markers_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sawm_pkg::*;

	localparam int OPCODE_MAX = 7;
	localparam int MARKER_KEEP = 16;

	typedef struct packed {
		logic [2:0]              status;
		logic [ADDR_BITS-1:0]    addr;
		logic [COUNT_BITS-1:0]   allocs;
		logic [COUNT_BITS-1:0]   frees;
		logic [CNT_BITS-1:0]     live;
	} alloc_reply_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [2:0]              opcode;
	logic [SIZE_BITS-1:0]    num_bytes;
	logic [ADDR_BITS-1:0]    address;
	logic                    done;
	logic [2:0]              status;
	logic [ADDR_BITS-1:0]    result_address;
	logic [COUNT_BITS-1:0]   alloc_count;
	logic [COUNT_BITS-1:0]   free_count;
	logic [CNT_BITS-1:0]     live_blocks;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [APB_AW-1:0]       paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;

	// Predicted allocator state and configuration
	logic [ADDR_BITS-1:0]    cfg_base;
	logic [SIZE_BITS-1:0]    cfg_size;
	logic [OFFSET_BITS-1:0]  top_off;
	logic [SIZE_BITS-1:0]    size_stack [RECORD_DEPTH];
	int unsigned             stack_depth;
	logic [COUNT_BITS-1:0]   alloc_total;
	logic [COUNT_BITS-1:0]   free_total;

	alloc_reply_t            pending_replies [$];
	logic [ADDR_BITS-1:0]    saved_markers [$];
	int                      error_count;
	bit                      idle_bursts;

	stack_allocator_with_markers_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.num_bytes      (num_bytes),
		.address        (address),
		.done           (done),
		.status         (status),
		.result_address (result_address),
		.alloc_count    (alloc_count),
		.free_count     (free_count),
		.live_blocks    (live_blocks),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Apply one request to the predicted state and return the reply it causes
	function automatic alloc_reply_t allocator_reply(logic [2:0] op, logic [SIZE_BITS-1:0] nb,
			logic [ADDR_BITS-1:0] ad);
		alloc_reply_t r;
		logic [31:0] cap;
		logic [31:0] top32;
		logic [31:0] last;
		logic [31:0] off;
		logic [31:0] cur;
		logic [31:0] sz;
		int unsigned pos;
		int unsigned popped;
		bit walking;
		r = '0;
		r.status = ST_OK;
		top32 = 32'(top_off);
		cap = 32'(cfg_size);
		if (cap > 32'(OFFSET_MASK)) cap = 32'(OFFSET_MASK);
		case (op)
			OP_ALLOC: begin
				// space check wins over the record check
				if (top32 > cap || cap - top32 < 32'(nb)) begin
					r.status = ST_NO_SPACE;
				end else if (stack_depth >= RECORD_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					r.addr = cfg_base + top32;
					top_off = top_off + nb;
					size_stack[stack_depth] = nb;
					stack_depth++;
					alloc_total++;
				end
			end
			OP_FREE: begin
				if (ad == '0) begin
					r.status = ST_IGNORED;
				end else if (stack_depth == 0) begin
					r.status = ST_NOT_LAST;
				end else begin
					last = 32'(size_stack[stack_depth-1]);
					if (last > top32 || ad != cfg_base + (top32 - last)) begin
						r.status = ST_NOT_LAST;
					end else begin
						top_off = OFFSET_BITS'(top32 - last);
						stack_depth--;
						free_total++;
					end
				end
			end
			OP_CLEAR: begin
				top_off = '0;
				stack_depth = 0;
				alloc_total = '0;
				free_total = '0;
			end
			OP_MARK: begin
			end
			OP_FTM: begin
				off = ad - cfg_base;
				if (ad == '0 || ad == cfg_base + top32) begin
					r.status = ST_IGNORED;
				end else begin
					r.status = ST_BAD_MARKER;
					if (off < top32) begin
						// pop records until the top lands exactly on the marker
						cur = top32;
						pos = stack_depth;
						popped = 0;
						walking = 1'b1;
						while (walking && pos > 0) begin
							sz = 32'(size_stack[pos-1]);
							if (sz > cur) begin
								walking = 1'b0;
							end else begin
								pos--;
								popped++;
								cur = cur - sz;
								if (cur == off) begin
									top_off = OFFSET_BITS'(cur);
									stack_depth = pos;
									free_total = free_total + popped;
									r.status = ST_OK;
									walking = 1'b0;
								end else if (cur < off) begin
									walking = 1'b0;
								end
							end
						end
					end
				end
			end
			default: begin
				r.status = ST_IGNORED;
			end
		endcase
		if (op != OP_ALLOC) r.addr = cfg_base + 32'(top_off);
		r.allocs = alloc_total;
		r.frees = free_total;
		r.live = CNT_BITS'(stack_depth);
		return r;
	endfunction

	// Address of the most recent block, or the top when the stack is empty
	function automatic logic [ADDR_BITS-1:0] last_block_address();
		if (stack_depth == 0) return cfg_base + 32'(top_off);
		return cfg_base + 32'(top_off) - 32'(size_stack[stack_depth-1]);
	endfunction

	// Present one request, hold it until taken, then maybe idle for a burst
	task automatic send_request(logic [2:0] op, logic [SIZE_BITS-1:0] nb,
			logic [ADDR_BITS-1:0] ad);
		start <= 1'b1;
		opcode <= op;
		num_bytes <= nb;
		address <= ad;
		do @(posedge clk); while (busy);
		pending_replies.insert(pending_replies.size(), allocator_reply(op, nb, ad));
		if (idle_bursts && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Drop start and wait until every predicted reply has come back
	task automatic drain_replies();
		start <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the bus stays selected after it
	task automatic write_register(logic reg_sel, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (reg_sel == REG_BUFFER_BASE) cfg_base = value;
		else cfg_size = value[SIZE_BITS-1:0];
	endtask

	// Write both registers back to back, then release the bus
	task automatic program_buffer(logic [31:0] base, logic [31:0] size);
		drain_replies();
		write_register(REG_BUFFER_BASE, base);
		write_register(REG_BUFFER_SIZE, size);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly well-formed traffic with some raw noise mixed in
	task automatic run_mixed(int count, bit allow_idle);
		logic [2:0] op;
		logic [SIZE_BITS-1:0] nb;
		logic [ADDR_BITS-1:0] ad;
		logic [31:0] span;
		int pick;
		int k;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) idle_bursts = allow_idle && $urandom_range(0, 3) != 0;
			pick = $urandom_range(0, 99);
			nb = '0;
			ad = '0;
			if (pick < 38) begin
				op = OP_ALLOC;
				if ($urandom_range(0, 4) == 0) nb = SIZE_BITS'($urandom_range(0, cfg_size));
				else nb = SIZE_BITS'($urandom_range(0, 48));
			end else if (pick < 58) begin
				op = OP_FREE;
				ad = last_block_address();
				if ($urandom_range(0, 5) == 0) ad = ad ^ (32'd1 << $urandom_range(0, 31));
			end else if (pick < 66) begin
				op = OP_MARK;
				saved_markers.insert(saved_markers.size(), cfg_base + 32'(top_off));
				if (saved_markers.size() > MARKER_KEEP) void'(saved_markers.pop_front());
			end else if (pick < 80) begin
				op = OP_FTM;
				if (stack_depth > 0 && $urandom_range(0, 2) != 0) begin
					// land on a real block boundary some records down
					k = $urandom_range(0, stack_depth - 1);
					span = '0;
					for (int j = 0; j <= k; j++) span += 32'(size_stack[stack_depth-1-j]);
					ad = cfg_base + 32'(top_off) - span;
				end else if (saved_markers.size() != 0) begin
					ad = saved_markers[$urandom_range(0, saved_markers.size() - 1)];
				end else begin
					ad = cfg_base + $urandom_range(0, 64);
				end
			end else if (pick < 83) begin
				op = OP_CLEAR;
				saved_markers.delete();
			end else begin
				op = 3'($urandom_range(0, OPCODE_MAX));
				nb = SIZE_BITS'($urandom);
				ad = $urandom;
			end
			send_request(op, nb, ad);
		end
	endtask

	// Null handling, empty stack, exact fill, refusals and unknown opcodes
	task automatic test_directed_cases();
		idle_bursts = 1'b1;
		send_request(OP_MARK, '0, '0);
		send_request(OP_FREE, '0, '0);
		send_request(OP_FREE, '0, cfg_base);
		send_request(OP_FTM, '0, '0);
		send_request(OP_FTM, '0, cfg_base);
		send_request(OP_ALLOC, '0, '0);
		send_request(OP_ALLOC, SIZE_BITS'(100), '0);
		send_request(OP_ALLOC, cfg_size - SIZE_BITS'(100), '0);
		send_request(OP_ALLOC, SIZE_BITS'(1), '0);
		send_request(OP_ALLOC, '1, '1);
		send_request(OP_FREE, '0, cfg_base);
		send_request(OP_FREE, '0, cfg_base + 32'd100);
		send_request(OP_FTM, '0, cfg_base + 32'd50);
		send_request(OP_FTM, '0, cfg_base + 32'd200);
		send_request(OP_FTM, '0, '1);
		send_request(OP_FTM, '0, cfg_base);
		send_request(OP_FREE, '0, cfg_base);
		send_request(OP_FREE, '0, cfg_base);
		for (int k = OP_FTM + 1; k <= OPCODE_MAX; k++) send_request(3'(k), '1, '1);
		send_request(OP_ALLOC, SIZE_BITS'(7), '0);
		send_request(OP_CLEAR, '1, '1);
		send_request(OP_MARK, '1, '1);
	endtask

	// Fill every record, overflow it, then unwind all of it to the base
	task automatic test_record_stack_full();
		idle_bursts = 1'b1;
		send_request(OP_CLEAR, '0, '0);
		for (int i = 0; i < RECORD_DEPTH + 4; i++)
			send_request(OP_ALLOC, SIZE_BITS'($urandom_range(1, 16)), '0);
		send_request(OP_FREE, '0, cfg_base);
		send_request(OP_FTM, '0, cfg_base);
		send_request(OP_MARK, '0, '0);
	endtask

	// Lower the size below the current top without clearing
	task automatic test_shrunk_buffer();
		send_request(OP_CLEAR, '0, '0);
		send_request(OP_ALLOC, SIZE_BITS'(1000), '0);
		send_request(OP_ALLOC, SIZE_BITS'(24), '0);
		program_buffer(cfg_base, 32'd500);
		send_request(OP_ALLOC, '0, '0);
		send_request(OP_FREE, '0, last_block_address());
		send_request(OP_ALLOC, '0, '0);
		send_request(OP_FREE, '0, last_block_address());
		send_request(OP_FREE, '0, last_block_address());
		send_request(OP_ALLOC, '0, '0);
	endtask

	// Random traffic under extreme and random buffer settings
	task automatic test_config_extremes();
		program_buffer(32'hFFFF_FFFF, 32'd1048576);
		run_mixed(90, 1'b1);
		program_buffer(32'h0000_0000, 32'd0);
		run_mixed(60, 1'b1);
		program_buffer(32'h8000_0000, 32'd300);
		run_mixed(90, 1'b1);
		program_buffer($urandom, $urandom_range(64, 4096));
		run_mixed(90, 1'b1);
	endtask

	// Back-to-back requests at reset settings, no sender gaps
	task automatic test_back_to_back();
		program_buffer(BASE_RESET, 32'(SIZE_RESET));
		run_mixed(130, 1'b0);
	endtask

	// Check every reply strobe against the oldest prediction
	task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
		if (expected !== actual) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : check_replies
		alloc_reply_t exp_r;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$error("reply with no request outstanding: status %0d", status);
				error_count++;
			end else begin
				exp_r = pending_replies.pop_front();
				check_field("status", 32'(exp_r.status), 32'(status));
				check_field("result_address", exp_r.addr, result_address);
				check_field("alloc_count", exp_r.allocs, alloc_count);
				check_field("free_count", exp_r.frees, free_count);
				check_field("live_blocks", 32'(exp_r.live), 32'(live_blocks));
			end
		end
	end

	// Reset, run each test in turn, then report
	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= OP_MARK;
		num_bytes <= '0;
		address <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cfg_base = BASE_RESET;
		cfg_size = SIZE_RESET;
		top_off = '0;
		stack_depth = 0;
		alloc_total = '0;
		free_total = '0;
		error_count = 0;
		idle_bursts = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_record_stack_full();
		test_shrunk_buffer();
		test_config_extremes();
		test_back_to_back();

		drain_replies();
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/sawm_pkg.sv
hdl/sawm_ram.sv
hdl/sawm_regs.sv
hdl/sawm_ctrl.sv
hdl/stack_allocator_with_markers_top.sv
bench/stack_allocator_with_markers_top_tb.sv
